FILE: sv/sac_pkg.sv
// shared types, constants and divider step functions for the swept box collision block
package sac_pkg;

	localparam int CW  = 24;
	localparam int TF  = 16;
	localparam int DW  = CW + 2;
	localparam int RW  = CW + 1;
	localparam int TW  = TF + 3;
	localparam int NST = TF + 1;
	localparam int QD  = 4;
	localparam int QAW = 2;

	localparam logic signed [TW-1:0] TSAT = TW'(64'd2 << TF);
	localparam logic signed [TW-1:0] TONE = TW'(64'd1 << TF);

	localparam logic signed [1:0] NRM_POS  = 2'sb01;
	localparam logic signed [1:0] NRM_NEG  = 2'sb11;
	localparam logic signed [1:0] NRM_NONE = 2'sb00;

	typedef struct packed {
		logic [DW-1:0] mag;
		logic          neg;
	} num_t;

	typedef struct packed {
		num_t          en;
		num_t          ex;
		logic [CW-1:0] den;
		logic          still;
		logic          vneg;
	} axis_t;

	typedef struct packed {
		axis_t ax;
		axis_t ay;
		logic  miss;
	} item_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [TF:0]   quo;
		logic          sat;
		logic          neg;
	} div_t;

	typedef struct packed {
		div_t [3:0]    q;
		logic [CW-1:0] den_x;
		logic [CW-1:0] den_y;
		logic          still_x;
		logic          still_y;
		logic          vneg_x;
		logic          vneg_y;
		logic          miss;
	} dstage_t;

	function automatic div_t div_init(input num_t n, input logic [CW-1:0] d);
		div_t          r;
		logic [CW:0]   two_d;
		logic          ge;
		two_d = {d, 1'b0};
		ge    = n.mag >= DW'(d);
		r.sat = n.mag >= DW'(two_d);
		r.rem = ge ? RW'(n.mag - DW'(d)) : RW'(n.mag);
		r.quo = (TF+1)'(ge);
		r.neg = n.neg;
		return r;
	endfunction

	function automatic div_t div_step(input div_t x, input logic [CW-1:0] d);
		div_t        r;
		logic [RW:0] sh;
		logic        ge;
		sh    = {x.rem, 1'b0};
		ge    = sh >= (RW+1)'(d);
		r.rem = ge ? RW'(sh - (RW+1)'(d)) : RW'(sh);
		r.quo = {x.quo[TF-1:0], ge};
		r.sat = x.sat;
		r.neg = x.neg;
		return r;
	endfunction

	function automatic logic signed [TW-1:0] div_fin(input div_t x);
		logic signed [TW-1:0] mag;
		logic signed [TW-1:0] v;
		logic                 sticky;
		mag    = x.sat ? TSAT : TW'(x.quo);
		sticky = !x.sat && (x.rem != '0);
		v      = -mag - TW'(sticky);
		if (v < -TSAT) begin
			v = -TSAT;
		end
		return x.neg ? v : mag;
	endfunction

endpackage

FILE: sv/sac_front.sv
// front part: edge distances, magnitudes, signs and still-axis classification
module sac_front (
	input  logic signed [sac_pkg::CW-1:0] moving_x,
	input  logic signed [sac_pkg::CW-1:0] moving_y,
	input  logic        [sac_pkg::CW-2:0] moving_w,
	input  logic        [sac_pkg::CW-2:0] moving_h,
	input  logic signed [sac_pkg::CW-1:0] fixed_x,
	input  logic signed [sac_pkg::CW-1:0] fixed_y,
	input  logic        [sac_pkg::CW-2:0] fixed_w,
	input  logic        [sac_pkg::CW-2:0] fixed_h,
	input  logic signed [sac_pkg::CW-1:0] vel_x,
	input  logic signed [sac_pkg::CW-1:0] vel_y,
	output sac_pkg::item_t                item
);
	import sac_pkg::*;

	function automatic num_t mk_num(input logic signed [DW-1:0] n, input logic vneg);
		num_t r;
		r.mag = (n < 0) ? DW'(-n) : DW'(n);
		r.neg = (n != '0) && ((n < 0) != vneg);
		return r;
	endfunction

	function automatic axis_t mk_axis(input logic signed [CW-1:0] mp,
	                                  input logic [CW-2:0] ms,
	                                  input logic signed [CW-1:0] fp,
	                                  input logic [CW-2:0] fs,
	                                  input logic signed [CW-1:0] v);
		axis_t                r;
		logic signed [DW-1:0] mp_e;
		logic signed [DW-1:0] ms_e;
		logic signed [DW-1:0] fp_e;
		logic signed [DW-1:0] fs_e;
		logic signed [DW-1:0] near;
		logic signed [DW-1:0] far;
		logic                 vneg;
		mp_e   = DW'(mp);
		fp_e   = DW'(fp);
		ms_e   = DW'(ms);
		fs_e   = DW'(fs);
		near   = fp_e - (mp_e + ms_e);
		far    = (fp_e + fs_e) - mp_e;
		vneg   = v < 0;
		r.en   = mk_num(vneg ? far : near, vneg);
		r.ex   = mk_num(vneg ? near : far, vneg);
		r.den  = vneg ? CW'(-v) : CW'(v);
		r.vneg = vneg;
		r.still = (v == '0);
		return r;
	endfunction

	logic ov_x, ov_y;
	logic signed [DW-1:0] nx_near, nx_far, ny_near, ny_far;

	always_comb begin
		item.ax = mk_axis(moving_x, moving_w, fixed_x, fixed_w, vel_x);
		item.ay = mk_axis(moving_y, moving_h, fixed_y, fixed_h, vel_y);
		nx_near = DW'(fixed_x) - (DW'(moving_x) + DW'(moving_w));
		nx_far  = (DW'(fixed_x) + DW'(fixed_w)) - DW'(moving_x);
		ny_near = DW'(fixed_y) - (DW'(moving_y) + DW'(moving_h));
		ny_far  = (DW'(fixed_y) + DW'(fixed_h)) - DW'(moving_y);
		// strict overlap on an axis
		ov_x = (nx_near < 0) && (nx_far > 0);
		ov_y = (ny_near < 0) && (ny_far > 0);
		item.miss = (item.ax.still && item.ay.still) ||
		            (item.ax.still && !ov_x) || (item.ay.still && !ov_y);
	end

endmodule

FILE: sv/sac_queue.sv
// short item queue between front and back
module sac_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sac_pkg::item_t wdata,
	output logic           full,
	input  logic           pop,
	output sac_pkg::item_t rdata,
	output logic           empty
);
	import sac_pkg::*;

	item_t          mem [QD];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign full    = cnt_q == (QAW+1)'(QD);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QAW'(QD-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QAW'(QD-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
		end
	end

endmodule

FILE: sv/sac_back.sv
// back part: pipelined restoring dividers, time combine and result register
module sac_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sac_pkg::item_t         item,
	input  logic                   in_vld,
	output logic                   take,
	input  logic                   pop,
	output logic                   empty,
	output logic                   hit,
	output logic [sac_pkg::TF:0]   hit_time,
	output logic signed [1:0]      normal_x,
	output logic signed [1:0]      normal_y
);
	import sac_pkg::*;

	typedef struct packed {
		logic signed [TW-1:0] enx;
		logic signed [TW-1:0] exx;
		logic signed [TW-1:0] eny;
		logic signed [TW-1:0] exy;
		logic                 vneg_x;
		logic                 vneg_y;
		logic                 miss;
	} fin_t;

	dstage_t              pipe_s [NST];
	dstage_t              pipe_d [NST];
	logic [NST-1:0]       vld_s;
	fin_t                 fin_s;
	logic                 fin_vld_s;
	logic                 out_vld_q;
	logic                 hit_q;
	logic [TF:0]          time_q;
	logic signed [1:0]    nx_q, ny_q;
	logic                 adv;
	dstage_t              st0;
	fin_t                 fin_d;
	logic signed [TW-1:0] entry, exit_t;
	logic                 ok, xsel;

	assign adv  = !out_vld_q || pop;
	assign take = adv;

	always_comb begin
		st0.q[0]    = div_init(item.ax.en, item.ax.den);
		st0.q[1]    = div_init(item.ax.ex, item.ax.den);
		st0.q[2]    = div_init(item.ay.en, item.ay.den);
		st0.q[3]    = div_init(item.ay.ex, item.ay.den);
		st0.den_x   = item.ax.den;
		st0.den_y   = item.ay.den;
		st0.still_x = item.ax.still;
		st0.still_y = item.ay.still;
		st0.vneg_x  = item.ax.vneg;
		st0.vneg_y  = item.ay.vneg;
		st0.miss    = item.miss;
	end

	always_comb begin
		pipe_d[0] = st0;
		for (int i = 1; i < NST; i++) begin
			pipe_d[i]      = pipe_s[i-1];
			pipe_d[i].q[0] = div_step(pipe_s[i-1].q[0], pipe_s[i-1].den_x);
			pipe_d[i].q[1] = div_step(pipe_s[i-1].q[1], pipe_s[i-1].den_x);
			pipe_d[i].q[2] = div_step(pipe_s[i-1].q[2], pipe_s[i-1].den_y);
			pipe_d[i].q[3] = div_step(pipe_s[i-1].q[3], pipe_s[i-1].den_y);
		end
	end

	always_comb begin
		fin_d.enx    = pipe_s[NST-1].still_x ? -TSAT : div_fin(pipe_s[NST-1].q[0]);
		fin_d.exx    = pipe_s[NST-1].still_x ?  TSAT : div_fin(pipe_s[NST-1].q[1]);
		fin_d.eny    = pipe_s[NST-1].still_y ? -TSAT : div_fin(pipe_s[NST-1].q[2]);
		fin_d.exy    = pipe_s[NST-1].still_y ?  TSAT : div_fin(pipe_s[NST-1].q[3]);
		fin_d.vneg_x = pipe_s[NST-1].vneg_x;
		fin_d.vneg_y = pipe_s[NST-1].vneg_y;
		fin_d.miss   = pipe_s[NST-1].miss;
	end

	always_comb begin
		xsel   = fin_s.enx > fin_s.eny;
		entry  = xsel ? fin_s.enx : fin_s.eny;
		exit_t = (fin_s.exx < fin_s.exy) ? fin_s.exx : fin_s.exy;
		ok     = !fin_s.miss && !(entry > exit_t) && (entry >= 0) && (entry <= TONE);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NST; i++) begin
				pipe_s[i] <= pipe_d[i];
			end
			fin_s  <= fin_d;
			hit_q  <= ok;
			time_q <= ok ? entry[TF:0] : '0;
			nx_q   <= (ok && xsel) ? (fin_s.vneg_x ? NRM_POS : NRM_NEG) : NRM_NONE;
			ny_q   <= (ok && !xsel) ? (fin_s.vneg_y ? NRM_POS : NRM_NEG) : NRM_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			fin_vld_s <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s     <= {vld_s[NST-2:0], in_vld};
			fin_vld_s <= vld_s[NST-1];
			out_vld_q <= fin_vld_s;
		end
	end

	assign empty    = !out_vld_q;
	assign hit      = hit_q;
	assign hit_time = time_q;
	assign normal_x = nx_q;
	assign normal_y = ny_q;

	a_one_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && hit_q) |-> ((nx_q != NRM_NONE) != (ny_q != NRM_NONE)))
		else $error("hit without exactly one normal axis");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !hit_q) |-> (time_q == '0 && nx_q == NRM_NONE && ny_q == NRM_NONE))
		else $error("miss with nonzero fields");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && hit_q) |-> (time_q <= TONE[TF:0]))
		else $error("hit time beyond one step");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !pop) |=> out_vld_q)
		else $error("result dropped while stalled");

endmodule

FILE: sv/swept_aabb_collision_top.sv
// swept box collision top level: front classify, item queue, divider back end
// path from push to empty falling: queue, divider stages, fin_s, result register
// throughput: one item per cycle when not stalled, set by the pipelined dividers
// the back end stalls as a whole while the result register is held
// reset: asynchronous active low, clears queue pointers and all valid flags
module swept_aabb_collision_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [sac_pkg::CW-1:0] moving_x,
	input  logic signed [sac_pkg::CW-1:0] moving_y,
	input  logic        [sac_pkg::CW-2:0] moving_w,
	input  logic        [sac_pkg::CW-2:0] moving_h,
	input  logic signed [sac_pkg::CW-1:0] fixed_x,
	input  logic signed [sac_pkg::CW-1:0] fixed_y,
	input  logic        [sac_pkg::CW-2:0] fixed_w,
	input  logic        [sac_pkg::CW-2:0] fixed_h,
	input  logic signed [sac_pkg::CW-1:0] vel_x,
	input  logic signed [sac_pkg::CW-1:0] vel_y,
	output logic                          empty,
	input  logic                          pop,
	output logic                          hit,
	output logic        [sac_pkg::TF:0]   hit_time,
	output logic signed [1:0]             normal_x,
	output logic signed [1:0]             normal_y
);
	import sac_pkg::*;

	item_t f_item, q_item;
	logic  q_empty, b_take;

	sac_front u_front (
		.moving_x (moving_x),
		.moving_y (moving_y),
		.moving_w (moving_w),
		.moving_h (moving_h),
		.fixed_x  (fixed_x),
		.fixed_y  (fixed_y),
		.fixed_w  (fixed_w),
		.fixed_h  (fixed_h),
		.vel_x    (vel_x),
		.vel_y    (vel_y),
		.item     (f_item)
	);

	sac_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_item),
		.full   (full),
		.pop    (b_take),
		.rdata  (q_item),
		.empty  (q_empty)
	);

	sac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (q_item),
		.in_vld   (!q_empty),
		.take     (b_take),
		.pop      (pop),
		.empty    (empty),
		.hit      (hit),
		.hit_time (hit_time),
		.normal_x (normal_x),
		.normal_y (normal_y)
	);

endmodule

FILE: dv/tb.sv
// self-checking testbench for the swept box collision block
module tb;
	import sac_pkg::*;

	typedef struct {
		logic signed [CW-1:0] mx, my, fx, fy, vx, vy;
		logic [CW-2:0] mw, mh, fw, fh;
	} box_pair_t;

	typedef struct {
		logic hit;
		logic [TF:0] t;
		logic signed [1:0] nx, ny;
	} contact_t;

	typedef struct {
		box_pair_t p;
		logic known;
		contact_t c;
	} row_t;

	localparam longint T2 = 64'sd2 << TF;
	localparam longint T1 = 64'sd1 << TF;
	localparam int LIMIT = 400000;

	logic clk, arst_n, push, pop;
	logic full, empty;
	logic signed [CW-1:0] moving_x, moving_y, fixed_x, fixed_y, vel_x, vel_y;
	logic [CW-2:0] moving_w, moving_h, fixed_w, fixed_h;
	logic hit;
	logic [TF:0] hit_time;
	logic signed [1:0] normal_x, normal_y;

	contact_t pending_contacts[$];
	row_t rows[$];
	int mismatches, results_seen, hits_seen, cycles;
	bit sending_done, hold_rx, pace_rx;

	swept_aabb_collision_top dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint time_quotient(longint n, longint d);
		longint an, ad, qi, r, frac, mag, v;
		bit sticky;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		qi = an / ad;
		r = an % ad;
		sticky = 0;
		if (qi >= 2) begin
			mag = T2;
		end else begin
			frac = 0;
			for (int i = 0; i < TF; i++) begin
				r = r << 1;
				frac = frac << 1;
				if (r >= ad) begin
					r -= ad;
					frac |= 1;
				end
			end
			mag = (qi << TF) | frac;
			sticky = r != 0;
		end
		if (an != 0 && ((n < 0) != (d < 0))) begin
			v = -mag - sticky;
			return v < -T2 ? -T2 : v;
		end
		return mag;
	endfunction

	function automatic bit axis_span(longint mp, longint ms, longint fp, longint fs,
			longint v, output longint en, output longint ex);
		en = 0;
		ex = 0;
		if (v > 0) begin
			en = time_quotient(fp - (mp + ms), v);
			ex = time_quotient((fp + fs) - mp, v);
		end else if (v < 0) begin
			en = time_quotient((fp + fs) - mp, v);
			ex = time_quotient(fp - (mp + ms), v);
		end else begin
			if (mp + ms <= fp || mp >= fp + fs) return 0;
			en = -T2;
			ex = T2;
		end
		return 1;
	endfunction

	function automatic contact_t sweep_contact(box_pair_t p);
		contact_t c;
		longint enx, exx, eny, exy, en, ex;
		c = '{0, 0, NRM_NONE, NRM_NONE};
		if (p.vx == 0 && p.vy == 0) return c;
		if (!axis_span(p.mx, p.mw, p.fx, p.fw, p.vx, enx, exx)) return c;
		if (!axis_span(p.my, p.mh, p.fy, p.fh, p.vy, eny, exy)) return c;
		en = enx > eny ? enx : eny;
		ex = exx < exy ? exx : exy;
		if (en > ex || en < 0 || en > T1) return c;
		c.hit = 1;
		c.t = en[TF:0];
		if (enx > eny) c.nx = p.vx < 0 ? NRM_POS : NRM_NEG;
		else c.ny = p.vy < 0 ? NRM_POS : NRM_NEG;
		return c;
	endfunction

	function automatic box_pair_t mk(longint mx, longint my, longint mw, longint mh,
			longint fx, longint fy, longint fw, longint fh, longint vx, longint vy);
		box_pair_t p;
		p.mx = CW'(mx); p.my = CW'(my); p.mw = (CW-1)'(mw); p.mh = (CW-1)'(mh);
		p.fx = CW'(fx); p.fy = CW'(fy); p.fw = (CW-1)'(fw); p.fh = (CW-1)'(fh);
		p.vx = CW'(vx); p.vy = CW'(vy);
		return p;
	endfunction

	function automatic logic [CW-1:0] rnd_coord(int mode);
		case (mode)
			0: return CW'($urandom);
			1: return CW'($signed($urandom_range(0, 8192)) - 4096);
			default: return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		endcase
	endfunction

	function automatic box_pair_t rnd_pair();
		box_pair_t p;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 7) begin
			p.fx = CW'($signed($urandom_range(0, 4000)) - 2000);
			p.fy = CW'($signed($urandom_range(0, 4000)) - 2000);
			p.fw = (CW-1)'($urandom_range(1, 1500));
			p.fh = (CW-1)'($urandom_range(1, 1500));
			p.mw = (CW-1)'($urandom_range(0, 1500));
			p.mh = (CW-1)'($urandom_range(0, 1500));
			p.mx = CW'($signed($urandom_range(0, 12000)) - 6000);
			p.my = CW'($signed($urandom_range(0, 12000)) - 6000);
			p.vx = $urandom_range(0, 5) == 0 ? '0 :
				CW'($signed(p.fx) - $signed(p.mx) + $signed($urandom_range(0, 6000)) - 3000);
			p.vy = $urandom_range(0, 5) == 0 ? '0 :
				CW'($signed(p.fy) - $signed(p.my) + $signed($urandom_range(0, 6000)) - 3000);
		end else begin
			p.mx = rnd_coord(mode - 7); p.my = rnd_coord(mode - 7);
			p.fx = rnd_coord(mode - 7); p.fy = rnd_coord(mode - 7);
			p.vx = rnd_coord(mode - 7); p.vy = rnd_coord(mode - 7);
			p.mw = (CW-1)'($urandom); p.mh = (CW-1)'($urandom);
			p.fw = (CW-1)'($urandom); p.fh = (CW-1)'($urandom);
		end
		return p;
	endfunction

	task automatic send(box_pair_t p, bit known, contact_t c, bit may_idle);
		while (may_idle && $urandom_range(0, 99) < 19) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		moving_x <= p.mx; moving_y <= p.my; moving_w <= p.mw; moving_h <= p.mh;
		fixed_x <= p.fx; fixed_y <= p.fy; fixed_w <= p.fw; fixed_h <= p.fh;
		vel_x <= p.vx; vel_y <= p.vy;
		pending_contacts.push_back(known ? c : sweep_contact(p));
		do @(posedge clk); while (full);
	endtask

	initial begin
		contact_t miss;
		miss = '{0, 0, NRM_NONE, NRM_NONE};
		push = 0; pop = 0; arst_n = 0;
		moving_x = 0; moving_y = 0; moving_w = 0; moving_h = 0;
		fixed_x = 0; fixed_y = 0; fixed_w = 0; fixed_h = 0;
		vel_x = 0; vel_y = 0;
		hold_rx = 0; pace_rx = 1; sending_done = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		rows.push_back('{mk(0, 0, 256, 256, 1024, 0, 256, 256, 0, 0), 1, miss});
		rows.push_back('{mk(0, 0, 256, 256, 1024, 0, 256, 256, 1024, 0), 1,
			'{1, 17'(3 << (TF - 2)), NRM_NEG, NRM_NONE}});
		rows.push_back('{mk(0, 0, 256, 256, 1024, 1024, 256, 256, 1024, 0), 1, miss});
		rows.push_back('{mk(0, 0, 256, 256, 0, 1024, 256, 256, 0, 768), 1,
			'{1, 17'(T1), NRM_NONE, NRM_NEG}});
		rows.push_back('{mk(2048, 0, 256, 256, 0, 0, 256, 256, -2048, 0), 1,
			'{1, 17'(7 << (TF - 3)), NRM_POS, NRM_NONE}});
		rows.push_back('{mk(0, 2048, 256, 256, 0, 0, 256, 256, 0, -1792), 1,
			'{1, 17'(T1), NRM_NONE, NRM_POS}});
		rows.push_back('{mk(0, 0, 256, 256, 512, 512, 256, 256, 512, 512), 1,
			'{1, 17'(1 << (TF - 1)), NRM_NONE, NRM_NEG}});
		rows.push_back('{mk(0, 0, 256, 256, 512, 0, 256, 256, 255, 0), 1, miss});
		rows.push_back('{mk(0, 0, 256, 256, 128, 128, 256, 256, 10, 0), 0, miss});
		rows.push_back('{mk(0, 0, 256, 256, 256, 0, 256, 256, 3, 0), 0, miss});
		rows.push_back('{mk(0, 0, 256, 256, 0, 256, 256, 256, 5, 0), 1, miss});
		rows.push_back('{mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607), 0, miss});
		rows.push_back('{mk(8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
			8388607, 8388607, -8388608, -8388608), 0, miss});
		rows.push_back('{mk(-8388608, 0, 0, 0, 8388607, 0, 0, 0, 1, -1), 0, miss});
		rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, -1, 1), 0, miss});
		rows.push_back('{mk(0, 0, 300, 300, 1000, 50, 10, 10, 3, 7), 0, miss});
		rows.push_back('{mk(0, 0, 256, 256, 100, 700, 256, 256, -3, 1000), 0, miss});
		rows.push_back('{mk(0, 0, 256, 256, 500, 500, 256, 256, 500, 500), 0, miss});
		foreach (rows[i]) send(rows[i].p, rows[i].known, rows[i].c, 0);
		push <= 0;

		for (int n = 0; n < 440; n++) begin
			if (n == 100) begin
				push <= 0;
				wait (pending_contacts.size() == 0);
				@(posedge clk);
			end
			if (n == 200) hold_rx <= 1;
			if (n == 260) pace_rx <= 0;
			if (n == 340) pace_rx <= 1;
			send(rnd_pair(), 0, miss, n < 260 || n >= 340);
		end
		push <= 0;
		sending_done = 1;
	end

	always @(posedge clk) begin
		if (hold_rx) begin
			pop <= 0;
			for (int i = 0; i < 60; i++) @(posedge clk);
			hold_rx <= 0;
		end else begin
			pop <= !pace_rx || $urandom_range(0, 99) >= 19;
		end
	end

	always @(posedge clk) begin
		contact_t e;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (pending_contacts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item hit=%0d", hit);
			end else begin
				e = pending_contacts.pop_front();
				hits_seen += e.hit;
				if (hit !== e.hit || hit_time !== e.t || normal_x !== e.nx ||
						normal_y !== e.ny) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
							e.hit, e.t, e.nx, e.ny, hit, hit_time, normal_x, normal_y);
				end
			end
		end
	end

	initial begin
		cycles = 0;
		while (!(sending_done && pending_contacts.size() == 0) && cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= LIMIT) begin
			$display("FAILURE");
		end else begin
			repeat (40) @(posedge clk);
			$display("checked %0d result items, %0d hits, including stall and drain phases",
				results_seen, hits_seen);
			if (mismatches == 0 && pending_contacts.size() == 0) begin
				$display("SUCCESS");
			end else begin
				$display("FAILURE");
			end
		end
		$finish;
	end
endmodule

FILE: files.f
sv/sac_pkg.sv
sv/sac_front.sv
sv/sac_queue.sv
sv/sac_back.sv
sv/swept_aabb_collision_top.sv
dv/tb.sv
